@@ sv/lzd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the LZ77 stream decoder.
// Used by every decoder module; depends on nothing.
package lzd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int SIZE_BITS    = 24;
  localparam int LEN_W        = 5;

  localparam logic [7:0]       TYPE_BYTE = 8'h10;
  localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(3);

  // One decoded result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
    logic       decode_error;
  } result_t;

  // Access to the history ring for one cycle.
  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
  } ram_req_t;

endpackage

@@ sv/lzd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the compressed input and decoded output.
// Stand-alone; depends on no other file.
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_stream;

  modport source (output valid, output in_byte, output new_stream, input ready);
  modport sink   (input valid, input in_byte, input new_stream, output ready);
endinterface

interface lzd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;
  logic       decode_error;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  output decode_error, input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  input decode_error, output ready);
endinterface

@@ sv/lzd_history.sv @@
`timescale 1ns / 1ps
// History ring: single-port-write, single-port-read synchronous RAM with
// registered read data. Depends on lzd_pkg.
module lzd_history (
  input  logic              clk,
  input  lzd_pkg::ram_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [lzd_pkg::WINDOW_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lzd_outq.sv @@
`timescale 1ns / 1ps
// Two-entry result queue: a ring of two registered entries, so the parser
// keeps taking input while a result waits. Depends on lzd_pkg.
module lzd_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lzd_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output lzd_pkg::result_t out_data
);

  lzd_pkg::result_t mem_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rptr_r];
  assign pop       = out_valid && out_ready;
  assign can_push  = (cnt_r != 2'd2) || out_ready;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ sv/lzd_core.sv @@
`timescale 1ns / 1ps
// Stream parser and match copy sequencer of the LZ77 decoder.
// Drives the history ring and the result queue. Depends on lzd_pkg.
module lzd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              new_stream,
  output logic              push,
  output lzd_pkg::result_t  push_data,
  input  logic              can_push,
  output lzd_pkg::ram_req_t ram_req,
  input  logic [7:0]        ram_q
);

  typedef enum logic [2:0] {
    PH_TYPE, PH_SIZE, PH_FLAG, PH_ITEM, PH_MATCH, PH_COPY, PH_DONE, PH_HALT
  } phase_t;

  localparam int SB = lzd_pkg::SIZE_BITS;
  localparam int AW = lzd_pkg::WIN_AW;
  localparam int LW = lzd_pkg::LEN_W;

  phase_t          phase_r, phase_nxt;
  logic [1:0]      hidx_r, hidx_nxt;
  logic [SB-1:0]   target_r, target_nxt;
  logic [SB-1:0]   produced_r, produced_nxt;
  logic [7:0]      flag_byte_r, flag_byte_nxt;
  logic [2:0]      flag_bit_r, flag_bit_nxt;
  logic [7:0]      match_high_r, match_high_nxt;
  logic [LW-1:0]   em_left_r, em_left_nxt;
  logic [LW-1:0]   iss_left_r, iss_left_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic            fwd_r, fwd_nxt;
  logic [7:0]      fwd_data_r, fwd_data_nxt;

  logic            accept;
  phase_t          ph_e;
  logic [SB-1:0]   prod_e, tgt_e, prod_inc, left;
  logic [1:0]      hidx_e;
  logic [31:0]     size_shift;
  logic [LW-1:0]   mlen;
  logic [AW:0]     mdist;
  logic [7:0]      copy_data;
  logic            emit_copy, issue, done_now;

  assign in_ready  = (phase_r != PH_COPY) && can_push;
  assign accept    = in_valid && in_ready;
  assign copy_data = fwd_r ? fwd_data_r : ram_q;
  assign emit_copy = (phase_r == PH_COPY) && pend_r && can_push;
  assign issue     = (phase_r == PH_COPY) && (iss_left_r != '0) && (!pend_r || emit_copy);

  // A new-stream mark restarts parsing before the byte is used.
  assign ph_e   = new_stream ? PH_TYPE : phase_r;
  assign prod_e = new_stream ? '0 : produced_r;
  assign tgt_e  = new_stream ? '0 : target_r;
  assign hidx_e = new_stream ? 2'd0 : hidx_r;

  assign prod_inc   = (accept ? prod_e : produced_r) + SB'(1);
  assign done_now   = (prod_inc == (accept ? tgt_e : target_r));
  assign size_shift = 32'(in_byte) << {hidx_e, 3'b000};
  assign mlen       = LW'(match_high_r[7:4]) + lzd_pkg::MIN_LEN;
  assign mdist      = {1'b0, match_high_r[3:0], in_byte} + (AW+1)'(1);
  assign left       = tgt_e - prod_e;

  always_comb begin
    phase_nxt      = phase_r;
    hidx_nxt       = hidx_r;
    target_nxt     = target_r;
    produced_nxt   = produced_r;
    flag_byte_nxt  = flag_byte_r;
    flag_bit_nxt   = flag_bit_r;
    match_high_nxt = match_high_r;
    em_left_nxt    = em_left_r;
    iss_left_nxt   = iss_left_r;
    pend_nxt       = pend_r;
    rd_addr_nxt    = rd_addr_r;
    fwd_nxt        = fwd_r;
    fwd_data_nxt   = fwd_data_r;
    push           = 1'b0;
    push_data      = '0;
    ram_req        = '0;

    if (accept) begin
      phase_nxt    = ph_e;
      produced_nxt = prod_e;
      target_nxt   = tgt_e;
      hidx_nxt     = hidx_e;
      case (ph_e)
        PH_TYPE: begin
          if (in_byte != lzd_pkg::TYPE_BYTE) begin
            push                   = 1'b1;
            push_data.run_last     = 1'b1;
            push_data.decode_error = 1'b1;
            phase_nxt              = PH_HALT;
          end else begin
            target_nxt = '0;
            hidx_nxt   = 2'd0;
            phase_nxt  = PH_SIZE;
          end
        end
        PH_SIZE: begin
          target_nxt = tgt_e | size_shift[SB-1:0];
          if (hidx_e == 2'd2) begin
            hidx_nxt  = 2'd0;
            phase_nxt = (target_nxt == '0) ? PH_DONE : PH_FLAG;
          end else begin
            hidx_nxt = hidx_e + 2'd1;
          end
        end
        PH_FLAG: begin
          flag_byte_nxt = in_byte;
          flag_bit_nxt  = 3'd7;
          phase_nxt     = PH_ITEM;
        end
        PH_ITEM: begin
          if (!flag_byte_r[flag_bit_r]) begin
            ram_req.we            = 1'b1;
            ram_req.waddr         = prod_e[AW-1:0];
            ram_req.wdata         = in_byte;
            push                  = 1'b1;
            push_data.out_byte    = in_byte;
            push_data.run_last    = 1'b1;
            push_data.stream_done = done_now;
            produced_nxt          = prod_inc;
            if (done_now) begin
              phase_nxt = PH_DONE;
            end else if (flag_bit_r == 3'd0) begin
              phase_nxt = PH_FLAG;
            end else begin
              flag_bit_nxt = flag_bit_r - 3'd1;
              phase_nxt    = PH_ITEM;
            end
          end else begin
            match_high_nxt = in_byte;
            phase_nxt      = PH_MATCH;
          end
        end
        PH_MATCH: begin
          if (SB'(mdist) > prod_e) begin
            push                   = 1'b1;
            push_data.run_last     = 1'b1;
            push_data.decode_error = 1'b1;
            phase_nxt              = PH_HALT;
          end else begin
            // The copy stops at the declared size.
            em_left_nxt  = (left < SB'(mlen)) ? left[LW-1:0] : mlen;
            iss_left_nxt = em_left_nxt;
            pend_nxt     = 1'b0;
            rd_addr_nxt  = prod_e[AW-1:0] - mdist[AW-1:0];
            phase_nxt    = PH_COPY;
          end
        end
        default: begin
        end
      endcase
    end

    if (emit_copy) begin
      ram_req.we            = 1'b1;
      ram_req.waddr         = produced_r[AW-1:0];
      ram_req.wdata         = copy_data;
      push                  = 1'b1;
      push_data.out_byte    = copy_data;
      push_data.run_last    = (em_left_r == LW'(1));
      push_data.stream_done = done_now;
      produced_nxt          = prod_inc;
      em_left_nxt           = em_left_r - LW'(1);
      if (em_left_r == LW'(1)) begin
        if (done_now) begin
          phase_nxt = PH_DONE;
        end else if (flag_bit_r == 3'd0) begin
          phase_nxt = PH_FLAG;
        end else begin
          flag_bit_nxt = flag_bit_r - 3'd1;
          phase_nxt    = PH_ITEM;
        end
      end
    end

    if (issue) begin
      ram_req.re   = 1'b1;
      ram_req.raddr = rd_addr_r;
      rd_addr_nxt  = rd_addr_r + AW'(1);
      iss_left_nxt = iss_left_r - LW'(1);
      // Reading the entry written in this same cycle takes the new byte.
      fwd_nxt      = emit_copy && (rd_addr_r == produced_r[AW-1:0]);
      fwd_data_nxt = copy_data;
    end

    if (phase_r == PH_COPY) begin
      pend_nxt = issue || (pend_r && !emit_copy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TYPE;
      hidx_r     <= 2'd0;
      target_r   <= '0;
      produced_r <= '0;
      flag_bit_r <= 3'd7;
      em_left_r  <= '0;
      iss_left_r <= '0;
      pend_r     <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hidx_r     <= hidx_nxt;
      target_r   <= target_nxt;
      produced_r <= produced_nxt;
      flag_bit_r <= flag_bit_nxt;
      em_left_r  <= em_left_nxt;
      iss_left_r <= iss_left_nxt;
      pend_r     <= pend_nxt;
      fwd_r      <= fwd_nxt;
    end
    flag_byte_r  <= flag_byte_nxt;
    match_high_r <= match_high_nxt;
    rd_addr_r    <= rd_addr_nxt;
    fwd_data_r   <= fwd_data_nxt;
  end

  // Bytes still to emit equal the reads not yet issued plus the outstanding read.
  a_copy_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COPY) |-> (em_left_r == iss_left_r + LW'(pend_r)))
    else $error("copy read and emit counts out of step");

  a_copy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COPY) |-> (em_left_r != '0))
    else $error("copy phase with nothing left to emit");

  a_below_target: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ITEM || phase_r == PH_MATCH || phase_r == PH_COPY)
      |-> (produced_r < target_r))
    else $error("decoding past the declared size");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("result pushed into a full queue");

  a_copy_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_copy && em_left_r == LW'(1)) |=> (phase_r != PH_COPY))
    else $error("copy did not end after its last byte");

endmodule

@@ sv/lz77_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// LZ77 stream decoder with a 4096-byte history ring. Header, flag, literal and
// error items act on accept; a literal result is pushed into the result queue.
// A match of n bytes (n up to 18) holds the input while it is copied, with one
// history read per byte, one byte out per cycle while the queue has room.
// Reset is synchronous: parser and queue clear, the history ring is not cleared.
module lz77_stream_decoder_top (
  input logic        clk,
  input logic        rst_n,
  lzd_in_if.sink     in_ch,
  lzd_out_if.source  out_ch
);

  lzd_pkg::result_t  push_data;
  lzd_pkg::result_t  out_data;
  lzd_pkg::ram_req_t ram_req;
  logic              push;
  logic              can_push;
  logic [7:0]        ram_q;

  lzd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .new_stream (in_ch.new_stream),
    .push       (push),
    .push_data  (push_data),
    .can_push   (can_push),
    .ram_req    (ram_req),
    .ram_q      (ram_q)
  );

  lzd_history u_history (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_q)
  );

  lzd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.out_byte     = out_data.out_byte;
  assign out_ch.run_last     = out_data.run_last;
  assign out_ch.stream_done  = out_data.stream_done;
  assign out_ch.decode_error = out_data.decode_error;

endmodule
